// ===== rtl/multi_queue_fifo_engine_macros.svh =====
// assertion macros for the multi-queue fifo engine
// used by the top level, expects clk_i and rst_ni in scope
`ifndef MULTI_QUEUE_FIFO_ENGINE_MACROS_SVH
`define MULTI_QUEUE_FIFO_ENGINE_MACROS_SVH

`ifndef SYNTHESIS
`define MQFE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("mqfe: assertion failed");
`define MQFE_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("mqfe: forbidden condition seen");
`else
`define MQFE_ASSERT(lbl, prop)
`define MQFE_ASSERT_NEVER(lbl, cond)
`endif

`endif

// ===== rtl/mqfe_pkg.sv =====
// shared types and default sizes for the multi-queue fifo engine
// no dependencies
package mqfe_pkg;

  localparam int unsigned NumQueuesDef = 8;
  localparam int unsigned PoolDepthDef = 256;
  localparam int unsigned DataWidthDef = 32;

  localparam int unsigned QueuesInUseRst = 8;

  typedef enum logic {
    OpEnq = 1'b0,
    OpDeq = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StEmpty = 2'd1,
    StFull  = 2'd2,
    StRange = 2'd3
  } status_e;

endpackage

// ===== rtl/mqfe_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module mqfe_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/multi_queue_fifo_engine.sv =====
// Multi-queue FIFO engine: NUM_QUEUES FIFO queues share a pool of POOL_DEPTH linked slots.
// Each request (enqueue or dequeue) is accepted in ST_IDLE, where the accepting edge reads the slot data
// and slot link memories; then in ST_EXEC the pointers, counts and free chain are
// updated, the memories written and the result registered, since the slot memories have
// a registered read port. ST_EXEC waits while the result register is still
// full and stalled. Status reports ok, queue empty, pool full or index out of range; the
// number of active queues is written through cfg_we_i/cfg_wdata_i and resets to 8.
// Depends on mqfe_pkg, mqfe_ram and multi_queue_fifo_engine_macros.svh.
`include "multi_queue_fifo_engine_macros.svh"

module multi_queue_fifo_engine #(
  parameter int unsigned NUM_QUEUES = mqfe_pkg::NumQueuesDef,
  parameter int unsigned POOL_DEPTH = mqfe_pkg::PoolDepthDef,
  parameter int unsigned DATA_WIDTH = mqfe_pkg::DataWidthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [3:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               op_i,
  input  logic [2:0]         queue_index_i,
  input  logic signed [31:0] value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         status_o,
  output logic signed [31:0] data_out_o
);
  import mqfe_pkg::*;

  localparam int unsigned PTR_W  = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(POOL_DEPTH + 1);
  localparam int unsigned QSEL_W = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic                  state_q, state_d;
  logic [3:0]            queues_in_use_q;
  logic                  op_q;
  logic [2:0]            idx_q;
  logic [31:0]           value_q;
  logic                  out_valid_q, out_valid_d;
  status_e               status_q, status_d;
  logic signed [31:0]    data_out_q, data_out_d;

  logic [PTR_W-1:0]      queue_head_q [NUM_QUEUES];
  logic [PTR_W-1:0]      queue_tail_q [NUM_QUEUES];
  logic [CNT_W-1:0]      queue_count_q [NUM_QUEUES];
  logic [CNT_W-1:0]      fresh_used_q, fresh_used_d;
  logic [PTR_W-1:0]      free_head_q, free_head_d;
  logic [CNT_W-1:0]      free_count_q, free_count_d;

  logic                  in_accept, exec_fire;
  logic [QSEL_W-1:0]     qsel, qexec;
  logic [PTR_W-1:0]      head_rd, tail_rd;
  logic [CNT_W-1:0]      count_rd;
  logic                  in_range;

  logic                  q_upd;
  logic [PTR_W-1:0]      head_d, tail_d;
  logic [CNT_W-1:0]      count_d;

  logic                  data_we, next_we;
  logic [PTR_W-1:0]      data_waddr, next_waddr, next_wdata, next_raddr, next_rdata;
  logic [DATA_WIDTH-1:0] data_wdata, data_rdata;
  logic [PTR_W-1:0]      slot;

  assign in_accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q == ST_EXEC);
  assign exec_fire = (state_q == ST_EXEC) && (!out_valid_q || !out_stall_i);

  // head read uses the request index when idle, held index when executing; tail/count use held index
  assign qexec   = QSEL_W'(idx_q);
  assign qsel    = (state_q == ST_EXEC) ? qexec : QSEL_W'(queue_index_i);
  assign head_rd = queue_head_q[qsel];
  assign tail_rd = queue_tail_q[qexec];
  assign count_rd = queue_count_q[qexec];

  assign in_range = ({1'b0, idx_q} < queues_in_use_q) && (32'(idx_q) < NUM_QUEUES);

  assign next_raddr = (op_i == OpDeq) ? head_rd : free_head_q;

  mqfe_ram #(
    .WIDTH(DATA_WIDTH),
    .DEPTH(POOL_DEPTH)
  ) u_data_ram (
    .clk_i  (clk_i),
    .we_i   (data_we),
    .waddr_i(data_waddr),
    .wdata_i(data_wdata),
    .re_i   (in_accept),
    .raddr_i(head_rd),
    .rdata_o(data_rdata)
  );

  mqfe_ram #(
    .WIDTH(PTR_W),
    .DEPTH(POOL_DEPTH)
  ) u_next_ram (
    .clk_i  (clk_i),
    .we_i   (next_we),
    .waddr_i(next_waddr),
    .wdata_i(next_wdata),
    .re_i   (in_accept),
    .raddr_i(next_raddr),
    .rdata_o(next_rdata)
  );

  always_comb begin
    state_d      = state_q;
    out_valid_d  = out_valid_q && out_stall_i;
    status_d     = status_q;
    data_out_d   = data_out_q;
    fresh_used_d = fresh_used_q;
    free_head_d  = free_head_q;
    free_count_d = free_count_q;
    q_upd        = 1'b0;
    head_d       = head_rd;
    tail_d       = tail_rd;
    count_d      = count_rd;
    data_we      = 1'b0;
    data_waddr   = '0;
    data_wdata   = DATA_WIDTH'($unsigned(value_q));
    next_we      = 1'b0;
    next_waddr   = '0;
    next_wdata   = '0;
    slot         = free_head_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (exec_fire) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
          status_d    = StOk;
          data_out_d  = '0;
          if (!in_range) begin
            status_d = StRange;
          end else if (op_q == OpEnq) begin
            if (free_count_q != '0) begin
              slot         = free_head_q;
              free_head_d  = next_rdata;
              free_count_d = free_count_q - CNT_W'(1);
            end else if (fresh_used_q < CNT_W'(POOL_DEPTH)) begin
              slot         = fresh_used_q[PTR_W-1:0];
              fresh_used_d = fresh_used_q + CNT_W'(1);
            end else begin
              status_d = StFull;
            end
            if (status_d == StOk) begin
              data_we    = 1'b1;
              data_waddr = slot;
              q_upd      = 1'b1;
              tail_d     = slot;
              count_d    = count_rd + CNT_W'(1);
              if (count_rd == '0) begin
                head_d = slot;
              end else begin
                next_we    = 1'b1;
                next_waddr = tail_rd;
                next_wdata = slot;
              end
            end
          end else begin
            if (count_rd == '0) begin
              status_d = StEmpty;
            end else begin
              data_out_d   = 32'($signed(data_rdata));
              q_upd        = 1'b1;
              head_d       = next_rdata;
              count_d      = count_rd - CNT_W'(1);
              next_we      = 1'b1;
              next_waddr   = head_rd;
              next_wdata   = free_head_q;
              free_head_d  = head_rd;
              free_count_d = free_count_q + CNT_W'(1);
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      queues_in_use_q <= 4'(QueuesInUseRst);
      out_valid_q     <= 1'b0;
      fresh_used_q    <= '0;
      free_head_q     <= '0;
      free_count_q    <= '0;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        queue_head_q[i]  <= '0;
        queue_tail_q[i]  <= '0;
        queue_count_q[i] <= '0;
      end
    end else begin
      state_q      <= state_d;
      out_valid_q  <= out_valid_d;
      fresh_used_q <= fresh_used_d;
      free_head_q  <= free_head_d;
      free_count_q <= free_count_d;
      if (cfg_we_i) begin
        queues_in_use_q <= cfg_wdata_i;
      end
      if (q_upd) begin
        queue_head_q[qexec]  <= head_d;
        queue_tail_q[qexec]  <= tail_d;
        queue_count_q[qexec] <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q    <= op_i;
      idx_q   <= queue_index_i;
      value_q <= value_i;
    end
    status_q   <= status_d;
    data_out_q <= data_out_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign data_out_o  = data_out_q;

  `MQFE_ASSERT(a_accept_to_exec, in_accept |=> (state_q == ST_EXEC))
  `MQFE_ASSERT(a_exec_loads_result, exec_fire |=> out_valid_q)
  `MQFE_ASSERT_NEVER(a_free_exceeds_used, free_count_q > fresh_used_q)
  `MQFE_ASSERT(a_full_only_when_exhausted,
               (exec_fire && status_d == StFull) |->
               (free_count_q == '0 && fresh_used_q == CNT_W'(POOL_DEPTH)))

endmodule
